// File: hw/rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and codes of the segregated free-list arena allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int SIZE_W = 6;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_HEAP_ALLOC  = 2'd0,
        CMD_FREE        = 2'd1,
        CMD_STACK_ALLOC = 2'd2,
        CMD_RELEASE     = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_OUT_OF_SPACE = 2'd1,
        STATUS_BAD_ARGUMENT = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic              step;
        cmd_t              cmd;
        logic [SIZE_W-1:0] size;
    } core_ctrl_t;

endpackage

// File: hw/rtl/sfla_req_if.sv
// ----------------------------------------------------------------------------
// sfla_req_if
// Request channel: command, block size and block address or stack mark.
// ----------------------------------------------------------------------------
interface sfla_req_if #(
    parameter int ADDR_W = 13
) ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [5:0]        block_size;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, output command, output block_size,
                    output block_address, input ready);
    modport sink   (input valid, input command, input block_size,
                    input block_address, output ready);
endinterface

// File: hw/rtl/sfla_rsp_if.sv
// ----------------------------------------------------------------------------
// sfla_rsp_if
// Result channel: allocated address, null flag, status and both tops.
// ----------------------------------------------------------------------------
interface sfla_rsp_if #(
    parameter int ADDR_W = 13
) ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              null_result;
    logic [1:0]        status;
    logic [ADDR_W-1:0] heap_top_now;
    logic [ADDR_W-1:0] stack_top_now;

    modport source (output valid, output address, output null_result,
                    output status, output heap_top_now, output stack_top_now,
                    input ready);
    modport sink   (input valid, input address, input null_result,
                    input status, input heap_top_now, input stack_top_now,
                    output ready);
endinterface

// File: hw/rtl/sfla_ram.sv
// ----------------------------------------------------------------------------
// sfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/sfla_core.sv
// ----------------------------------------------------------------------------
// sfla_core
// Heap and stack tops, free-list heads and the per-request decision logic.
// ----------------------------------------------------------------------------
module sfla_core import sfla_pkg::*; #(
    parameter int ARENA_CELLS = 4096,
    parameter int MAX_BLOCK   = 16,
    parameter int ADDR_W      = 13,
    parameter int IDX_W       = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  core_ctrl_t        ctrl,
    input  logic [ADDR_W-1:0] where,
    input  logic [SIZE_W-1:0] lookup_size,
    input  logic [ADDR_W-1:0] link_rdata,
    output logic [IDX_W-1:0]  link_raddr,
    output logic              link_we,
    output logic [IDX_W-1:0]  link_waddr,
    output logic [ADDR_W-1:0] link_wdata,
    output logic [ADDR_W-1:0] res_address,
    output logic              res_null,
    output status_t           res_status,
    output logic [ADDR_W-1:0] res_heap_top,
    output logic [ADDR_W-1:0] res_stack_top
);
    localparam int HEADS  = MAX_BLOCK + 1;
    localparam int HIDX_W = $clog2(HEADS);
    localparam int SUM_W  = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 1;
    localparam logic [ADDR_W-1:0] NULL_ADDR = ADDR_W'(ARENA_CELLS);
    localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(MAX_BLOCK);

    logic [ADDR_W-1:0] heap_top_reg, heap_top_next;
    logic [ADDR_W-1:0] stack_top_reg, stack_top_next;
    logic [ADDR_W-1:0] heads_reg [HEADS];
    logic              head_we;
    logic [ADDR_W-1:0] head_wdata;

    logic [HIDX_W-1:0] lookup_idx;
    logic [HIDX_W-1:0] cur_idx;
    logic [ADDR_W-1:0] cur_head;
    logic [SUM_W-1:0]  heap_sum;
    logic              no_room;
    logic              oversize;

    // link read issued as the request is taken, using the head for its size
    assign lookup_idx = (lookup_size > MAX_SIZE) ? '0 : lookup_size[HIDX_W-1:0];
    assign link_raddr = heads_reg[lookup_idx][IDX_W-1:0];

    assign cur_idx  = (ctrl.size > MAX_SIZE) ? '0 : ctrl.size[HIDX_W-1:0];
    assign cur_head = heads_reg[cur_idx];
    assign oversize = ctrl.size > MAX_SIZE;
    assign heap_sum = SUM_W'(heap_top_reg) + SUM_W'(ctrl.size);
    assign no_room  = SUM_W'(stack_top_reg) <= heap_sum;

    always_comb
    begin
        heap_top_next  = heap_top_reg;
        stack_top_next = stack_top_reg;
        head_we        = 1'b0;
        head_wdata     = link_rdata;
        link_we        = 1'b0;
        link_waddr     = where[IDX_W-1:0];
        link_wdata     = cur_head;
        res_address    = NULL_ADDR;
        res_null       = 1'b0;
        res_status     = STATUS_OK;
        unique case (ctrl.cmd)
            CMD_HEAP_ALLOC:
            begin
                if (ctrl.size == '0)
                begin
                    res_null = 1'b1;
                end
                else if (oversize)
                begin
                    res_status = STATUS_BAD_ARGUMENT;
                end
                else if (cur_head < NULL_ADDR)
                begin
                    res_address = cur_head;
                    head_we     = 1'b1;
                    head_wdata  = link_rdata;
                end
                else if (no_room)
                begin
                    res_status = STATUS_OUT_OF_SPACE;
                end
                else
                begin
                    res_address   = heap_top_reg;
                    heap_top_next = heap_sum[ADDR_W-1:0];
                end
            end
            CMD_FREE:
            begin
                if (ctrl.size == '0)
                begin
                    res_status = STATUS_OK;
                end
                else if (oversize || where >= NULL_ADDR)
                begin
                    res_status = STATUS_BAD_ARGUMENT;
                end
                else
                begin
                    link_we    = 1'b1;
                    head_we    = 1'b1;
                    head_wdata = where;
                end
            end
            CMD_STACK_ALLOC:
            begin
                if (ctrl.size == '0)
                begin
                    res_null = 1'b1;
                end
                else if (no_room)
                begin
                    res_status = STATUS_OUT_OF_SPACE;
                end
                else
                begin
                    stack_top_next = stack_top_reg - ADDR_W'(ctrl.size);
                    res_address    = stack_top_next;
                end
            end
            CMD_RELEASE:
            begin
                if (where < heap_top_reg || where > NULL_ADDR)
                begin
                    res_status = STATUS_BAD_ARGUMENT;
                end
                else
                begin
                    stack_top_next = where;
                end
            end
            default:
            begin
                res_status = STATUS_BAD_ARGUMENT;
            end
        endcase
        link_we       = link_we & ctrl.step;
        res_heap_top  = heap_top_next;
        res_stack_top = stack_top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_top_reg  <= '0;
            stack_top_reg <= NULL_ADDR;
            for (int i = 0; i < HEADS; i++)
            begin
                heads_reg[i] <= NULL_ADDR;
            end
        end
        else if (ctrl.step)
        begin
            heap_top_reg  <= heap_top_next;
            stack_top_reg <= stack_top_next;
            if (head_we)
            begin
                heads_reg[cur_idx] <= head_wdata;
            end
        end
    end
endmodule

// File: hw/rtl/segregated_free_list_arena_allocator_top.sv
// ----------------------------------------------------------------------------
// segregated_free_list_arena_allocator_top
// Arena allocator with a bump heap, a downward stack and per-size free lists.
// ----------------------------------------------------------------------------
// usage
//   request channel: command, block_size, block_address (free address or
//   stack mark); taken when valid and ready are both high
//   result channel: one result per request, held in an output register
//   until the receiver takes it
//   a taken request moves to the execute state, whose outcome is written to
//   the output register; no new request is taken while one is executing;
//   the link cell of a free-list pop is read from the link ram in the cycle
//   after acceptance, and the list head is updated in that same cycle
//   the next request is taken while a result waits, once that result is
//   being taken in the same cycle; a stalled receiver holds the result and
//   stops new requests
//   reset: heap top zero, stack top at arena end, every free list empty;
//   the link ram needs no clearing, so requests are taken right after reset
// ----------------------------------------------------------------------------
module segregated_free_list_arena_allocator_top import sfla_pkg::*; #(
    parameter int ARENA_CELLS = 4096,
    parameter int MAX_BLOCK   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sfla_req_if.sink   request,
    sfla_rsp_if.source result
);
    localparam int ADDR_W = $clog2(ARENA_CELLS + 1);
    localparam int IDX_W  = $clog2(ARENA_CELLS);

    fsm_state_t        state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              accept;
    logic              step;

    cmd_t              cmd_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] where_reg;

    logic [ADDR_W-1:0] address_reg;
    logic              null_reg;
    status_t           status_reg;
    logic [ADDR_W-1:0] heap_top_reg;
    logic [ADDR_W-1:0] stack_top_reg;

    core_ctrl_t        ctrl;
    logic [IDX_W-1:0]  link_raddr;
    logic [ADDR_W-1:0] link_rdata;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [ADDR_W-1:0] link_wdata;
    logic [ADDR_W-1:0] res_address;
    logic              res_null;
    status_t           res_status;
    logic [ADDR_W-1:0] res_heap_top;
    logic [ADDR_W-1:0] res_stack_top;

    assign request.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || result.ready);
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        step           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (result.ready)
                begin
                    rsp_valid_next = 1'b0;
                end
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                step           = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_HEAP_ALLOC;
            size_reg      <= '0;
            where_reg     <= '0;
            address_reg   <= '0;
            null_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
            heap_top_reg  <= '0;
            stack_top_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                cmd_reg   <= cmd_t'(request.command);
                size_reg  <= request.block_size;
                where_reg <= request.block_address;
            end
            if (step)
            begin
                address_reg   <= res_address;
                null_reg      <= res_null;
                status_reg    <= res_status;
                heap_top_reg  <= res_heap_top;
                stack_top_reg <= res_stack_top;
            end
        end
    end

    assign ctrl.step = step;
    assign ctrl.cmd  = cmd_reg;
    assign ctrl.size = size_reg;

    sfla_core #(
        .ARENA_CELLS (ARENA_CELLS),
        .MAX_BLOCK   (MAX_BLOCK),
        .ADDR_W      (ADDR_W),
        .IDX_W       (IDX_W)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .where         (where_reg),
        .lookup_size   (request.block_size),
        .link_rdata    (link_rdata),
        .link_raddr    (link_raddr),
        .link_we       (link_we),
        .link_waddr    (link_waddr),
        .link_wdata    (link_wdata),
        .res_address   (res_address),
        .res_null      (res_null),
        .res_status    (res_status),
        .res_heap_top  (res_heap_top),
        .res_stack_top (res_stack_top)
    );

    sfla_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (ARENA_CELLS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign result.valid         = rsp_valid_reg;
    assign result.address       = address_reg;
    assign result.null_result   = null_reg;
    assign result.status        = status_reg;
    assign result.heap_top_now  = heap_top_reg;
    assign result.stack_top_now = stack_top_reg;

    // execute cycle only starts with the output register free
    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !rsp_valid_reg)
        else $error("execute cycle with pending result");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC) && !request.ready)
        else $error("accepted request did not enter execute");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> rsp_valid_reg)
        else $error("execute cycle gave no result");

    a_tops_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (heap_top_reg <= stack_top_reg))
        else $error("heap top above stack top");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segregated free-list arena allocator. A
// behavioral copy of the arena (heap top, stack top, per-size free lists and
// link cells) predicts every result. Each taken result is compared field by
// field against the oldest prediction. Stimulus is a directed pass over the
// corner cases, then random allocate/free/stack/release traffic under several
// idle and stall mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import sfla_pkg::*;

    localparam int ARENA_CELLS = 4096;
    localparam int MAX_BLOCK   = 16;
    localparam int IDLE_LIMIT  = 3000;
    localparam int RANDOM_REQS = 700;

    typedef struct {
        logic [12:0] address;
        logic        null_result;
        status_t     status;
        logic [12:0] heap_top_now;
        logic [12:0] stack_top_now;
    } arena_result_t;

    class arena_model;
        int unsigned   heap_top;
        int unsigned   stack_top;
        int unsigned   free_heads [MAX_BLOCK+1];
        int unsigned   link_cells [int unsigned];
        arena_result_t pending_results [$];
        int unsigned   live_addr [$];
        int unsigned   live_size [$];
        int unsigned   marks [$];
        int            errors;
        int            requests_seen;
        int            results_seen;
        int            pops;
        int            bumps;
        int            pushes;
        int            out_of_space;
        int            bad_args;
        int            nulls;

        function new();
            heap_top  = 0;
            stack_top = ARENA_CELLS;
            foreach (free_heads[i])
                free_heads[i] = ARENA_CELLS;
        endfunction

        function void note_request(cmd_t cmd, logic [5:0] size, logic [12:0] where);
            arena_result_t r;
            int unsigned   n;
            int unsigned   a;
            n = size;
            a = where;
            r.address     = 13'(ARENA_CELLS);
            r.null_result = 1'b0;
            r.status      = STATUS_OK;
            requests_seen++;
            case (cmd)
                CMD_HEAP_ALLOC:
                begin
                    if (n == 0)
                        r.null_result = 1'b1;
                    else if (n > MAX_BLOCK)
                        r.status = STATUS_BAD_ARGUMENT;
                    else if (free_heads[n] < ARENA_CELLS)
                    begin
                        r.address     = 13'(free_heads[n]);
                        live_addr.push_back(free_heads[n]);
                        live_size.push_back(n);
                        free_heads[n] = link_cells[free_heads[n]];
                        pops++;
                    end
                    else if (stack_top <= heap_top + n)
                        r.status = STATUS_OUT_OF_SPACE;
                    else
                    begin
                        r.address = 13'(heap_top);
                        live_addr.push_back(heap_top);
                        live_size.push_back(n);
                        heap_top += n;
                        bumps++;
                    end
                end
                CMD_FREE:
                begin
                    if (n == 0)
                        ;
                    else if (n > MAX_BLOCK || a >= ARENA_CELLS)
                        r.status = STATUS_BAD_ARGUMENT;
                    else
                    begin
                        link_cells[a] = free_heads[n];
                        free_heads[n] = a;
                        pushes++;
                    end
                end
                CMD_STACK_ALLOC:
                begin
                    if (n == 0)
                        r.null_result = 1'b1;
                    else if (stack_top <= heap_top + n)
                        r.status = STATUS_OUT_OF_SPACE;
                    else
                    begin
                        stack_top -= n;
                        r.address  = 13'(stack_top);
                        marks.push_back(stack_top);
                    end
                end
                default:
                begin
                    if (a < heap_top || a > ARENA_CELLS)
                        r.status = STATUS_BAD_ARGUMENT;
                    else
                        stack_top = a;
                end
            endcase
            if (r.null_result)
                nulls++;
            if (r.status == STATUS_OUT_OF_SPACE)
                out_of_space++;
            if (r.status == STATUS_BAD_ARGUMENT)
                bad_args++;
            r.heap_top_now  = 13'(heap_top);
            r.stack_top_now = 13'(stack_top);
            pending_results.push_back(r);
        endfunction

        function void report_mismatch(string field, logic [12:0] want, logic [12:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(arena_result_t got);
            arena_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, address %0d status %0d",
                         $time, got.address, got.status);
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (got.address !== want.address)
                report_mismatch("address", want.address, got.address);
            if (got.null_result !== want.null_result)
                report_mismatch("null_result", 13'(want.null_result), 13'(got.null_result));
            if (got.status !== want.status)
                report_mismatch("status", 13'(want.status), 13'(got.status));
            if (got.heap_top_now !== want.heap_top_now)
                report_mismatch("heap_top_now", want.heap_top_now, got.heap_top_now);
            if (got.stack_top_now !== want.stack_top_now)
                report_mismatch("stack_top_now", want.stack_top_now, got.stack_top_now);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sfla_req_if #(.ADDR_W(13)) req_ch ();
    sfla_rsp_if #(.ADDR_W(13)) rsp_ch ();

    segregated_free_list_arena_allocator_top #(
        .ARENA_CELLS (ARENA_CELLS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch)
    );

    arena_model tracker;
    int         idle_pct   = 0;
    int         stall_pct  = 0;
    int         hold_count = 0;
    int         quiet_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_count > 0)
            begin
                hold_count--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        arena_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.address       = rsp_ch.address;
            got.null_result   = rsp_ch.null_result;
            got.status        = status_t'(rsp_ch.status);
            got.heap_top_now  = rsp_ch.heap_top_now;
            got.stack_top_now = rsp_ch.stack_top_now;
            tracker.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(cmd_t cmd, int unsigned size, int unsigned where);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.command       <= cmd;
        req_ch.block_size    <= 6'(size);
        req_ch.block_address <= 13'(where);
        req_ch.valid         <= 1'b1;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        tracker.note_request(cmd, 6'(size), 13'(where));
    endtask

    task automatic run_directed();
        send_request(CMD_HEAP_ALLOC, 0, 0);
        send_request(CMD_HEAP_ALLOC, 63, 0);
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK + 1, 0);
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK, 0);
        send_request(CMD_HEAP_ALLOC, 1, 0);
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK, 0);
        send_request(CMD_FREE, MAX_BLOCK, 0);
        send_request(CMD_FREE, MAX_BLOCK, MAX_BLOCK + 1);
        // lifo reuse, then an empty list falls back to the bump
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK, 0);
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK, 0);
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK, 0);
        send_request(CMD_FREE, 0, 5);
        send_request(CMD_FREE, 63, 0);
        send_request(CMD_FREE, 1, ARENA_CELLS);
        send_request(CMD_FREE, 1, 8191);
        send_request(CMD_FREE, 1, ARENA_CELLS - 1);
        send_request(CMD_HEAP_ALLOC, 1, 0);
        send_request(CMD_STACK_ALLOC, 0, 8191);
        send_request(CMD_STACK_ALLOC, 63, 0);
        send_request(CMD_RELEASE, 0, ARENA_CELLS + 1);
        send_request(CMD_RELEASE, 0, tracker.heap_top - 1);
        send_request(CMD_RELEASE, 0, tracker.heap_top + 20);
        send_request(CMD_HEAP_ALLOC, MAX_BLOCK, 0);
        send_request(CMD_HEAP_ALLOC, 4, 0);
        send_request(CMD_STACK_ALLOC, 4, 0);
        send_request(CMD_STACK_ALLOC, 3, 0);
        send_request(CMD_RELEASE, 0, tracker.heap_top);
        send_request(CMD_RELEASE, 0, ARENA_CELLS);
    endtask

    task automatic random_request();
        int unsigned pick;
        int unsigned idx;
        int unsigned size;
        pick = $urandom_range(99);
        if (pick < 12)
            send_request(cmd_t'($urandom_range(3)), $urandom_range(63), $urandom_range(8191));
        else if (pick < 67 && pick >= 42 && tracker.live_addr.size() != 0)
        begin
            idx = $urandom_range(tracker.live_addr.size() - 1);
            send_request(CMD_FREE, tracker.live_size[idx], tracker.live_addr[idx]);
            tracker.live_addr.delete(idx);
            tracker.live_size.delete(idx);
        end
        else if (pick < 67)
        begin
            size = $urandom_range(1, ($urandom_range(3) == 0) ? MAX_BLOCK : 4);
            send_request(CMD_HEAP_ALLOC, size, $urandom_range(8191));
        end
        else if (pick < 85)
            send_request(CMD_STACK_ALLOC, $urandom_range(1, 48), $urandom_range(8191));
        else if (pick < 92 && tracker.marks.size() != 0)
            send_request(CMD_RELEASE, $urandom_range(63),
                         tracker.marks[$urandom_range(tracker.marks.size() - 1)]);
        else if (pick < 96)
            // squeeze the gap so both sides run into each other
            send_request(CMD_RELEASE, $urandom_range(63),
                         tracker.heap_top + $urandom_range(40));
        else
            send_request(CMD_RELEASE, $urandom_range(63), ARENA_CELLS);
    endtask

    initial
    begin
        int sender_mix [8]   = '{0, 79, 0, 27, 0, 27, 79, 0};
        int receiver_mix [8] = '{0, 0, 79, 27, 0, 27, 0, 79};
        tracker = new();
        req_ch.valid         <= 1'b0;
        req_ch.command       <= CMD_HEAP_ALLOC;
        req_ch.block_size    <= '0;
        req_ch.block_address <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 8; phase++)
        begin
            idle_pct  = sender_mix[phase];
            stall_pct = receiver_mix[phase];
            if (phase == 4)
                hold_count = 60;
            for (int k = 0; k < RANDOM_REQS / 8; k++)
                random_request();
        end
        req_ch.valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d list pops, %0d bumps",
                 tracker.requests_seen, tracker.results_seen, tracker.pops, tracker.bumps);
        $display("frees pushed %0d, out of space %0d, bad argument %0d, null %0d",
                 tracker.pushes, tracker.out_of_space, tracker.bad_args, tracker.nulls);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
